// File: rtl/core/eau_pkg.sv
// ---------------------------------------------------------------------------
// eau_pkg - shared types for the 6502 effective address unit
// Item and result layouts, addressing mode codes and resolution phases.
// ---------------------------------------------------------------------------
package eau_pkg;

    localparam int unsigned SDATA_W = 48;  // 45 payload bits, padded to bytes
    localparam int unsigned MDATA_W = 24;  // 17 payload bits, padded to bytes

    typedef enum logic [3:0] {
        MODE_IMM  = 4'd0,
        MODE_ZP   = 4'd1,
        MODE_ZPX  = 4'd2,
        MODE_ZPY  = 4'd3,
        MODE_REL  = 4'd4,
        MODE_ABS  = 4'd5,
        MODE_ABSX = 4'd6,
        MODE_ABSY = 4'd7,
        MODE_IND  = 4'd8,
        MODE_INDX = 4'd9,
        MODE_INDY = 4'd10
    } t_mode;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_OPLO  = 3'd1,
        PH_OPHI  = 3'd2,
        PH_PTRLO = 3'd3,
        PH_PTRHI = 3'd4
    } t_phase;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_DATA  = 1'b1;

    typedef struct packed {
        logic        func;
        logic [3:0]  mode;
        logic [15:0] operand_address;
        logic [7:0]  index_x;
        logic [7:0]  index_y;
        logic        need_value;
        logic [7:0]  read_data;
    } t_in_item;

    typedef struct packed {
        logic        done_res;
        logic [15:0] address;
        logic        page_crossed;
    } t_result;

    // Handshake between input stage and result stage
    typedef struct packed {
        logic full;   // input register holds an item
        logic take;   // result register can load this cycle
    } t_stage_ctl;

endpackage

// File: rtl/core/eau_in_stage.sv
// ---------------------------------------------------------------------------
// eau_in_stage - input register
// Holds one accepted item until the result register can take its result.
// ---------------------------------------------------------------------------
module eau_in_stage
    import eau_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_in_item   i_item,
    input  logic       i_take,
    output logic       o_fire,
    output t_stage_ctl o_ctl,
    output t_in_item   o_item
);

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;

    assign o_fire  = r_valid & i_take;
    assign o_ready = ~r_valid | o_fire;
    assign n_valid = (i_valid & o_ready) | (r_valid & ~o_fire);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload only
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_item    = r_item;
    assign o_ctl     = '{full: r_valid, take: i_take};

endmodule

// File: rtl/core/eau_core.sv
// ---------------------------------------------------------------------------
// eau_core - address resolution step
// Holds the resolution state and works out one result per fired item.
// ---------------------------------------------------------------------------
module eau_core
    import eau_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_fire,
    input  t_in_item i_item,
    output t_result  o_res
);

    t_phase      r_phase,  n_phase;
    logic [3:0]  r_mode,   n_mode;
    logic [7:0]  r_x,      n_x;
    logic [7:0]  r_y,      n_y;
    logic        r_value,  n_value;
    logic [7:0]  r_low,    n_low;
    logic [15:0] r_work,   n_work;

    logic [7:0]  d;
    logic [15:0] base;
    logic [7:0]  idx;
    logic [15:0] ea;
    logic        crossed;
    t_result     res;

    assign d    = i_item.read_data;
    assign base = {d, r_low};
    assign idx  = (r_mode == MODE_ABSX) ? r_x : r_y;
    assign ea   = base + {8'h00, idx};
    // page cross only counts for value reads
    assign crossed = r_value & (ea[15:8] != base[15:8]);

    always_comb begin
        n_phase = r_phase;
        n_mode  = r_mode;
        n_x     = r_x;
        n_y     = r_y;
        n_value = r_value;
        n_low   = r_low;
        n_work  = r_work;
        res     = '{done_res: 1'b1, address: 16'h0000, page_crossed: 1'b0};

        if (i_item.func == FUNC_START) begin
            // a start abandons anything in flight
            n_mode  = i_item.mode;
            n_x     = i_item.index_x;
            n_y     = i_item.index_y;
            n_value = i_item.need_value;
            unique case (i_item.mode)
                MODE_IMM, MODE_REL: begin
                    n_phase     = PH_IDLE;
                    res.address = i_item.operand_address;
                end
                MODE_ZP, MODE_ZPX, MODE_ZPY, MODE_ABS, MODE_ABSX, MODE_ABSY,
                MODE_IND, MODE_INDX, MODE_INDY: begin
                    n_phase      = PH_OPLO;
                    n_work       = i_item.operand_address;
                    res.done_res = 1'b0;
                    res.address  = i_item.operand_address;
                end
                default: begin
                    n_phase = PH_IDLE;   // unknown mode ends at zero
                end
            endcase
        end else begin
            unique case (r_phase)
                PH_OPLO: begin
                    case (r_mode)
                        MODE_ZP: begin
                            n_phase     = PH_IDLE;
                            res.address = {8'h00, d};
                        end
                        MODE_ZPX: begin
                            n_phase     = PH_IDLE;
                            res.address = {8'h00, d + r_x};
                        end
                        MODE_ZPY: begin
                            n_phase     = PH_IDLE;
                            res.address = {8'h00, d + r_y};
                        end
                        MODE_INDX: begin
                            n_phase      = PH_PTRLO;
                            n_work       = {8'h00, d + r_x};
                            res.done_res = 1'b0;
                            res.address  = {8'h00, d + r_x};
                        end
                        MODE_INDY: begin
                            n_phase      = PH_PTRLO;
                            n_work       = {8'h00, d};
                            res.done_res = 1'b0;
                            res.address  = {8'h00, d};
                        end
                        default: begin
                            n_low        = d;
                            n_phase      = PH_OPHI;
                            n_work       = r_work + 16'd1;
                            res.done_res = 1'b0;
                            res.address  = r_work + 16'd1;
                        end
                    endcase
                end
                PH_OPHI: begin
                    case (r_mode)
                        MODE_ABSX, MODE_ABSY: begin
                            n_phase          = PH_IDLE;
                            res.address      = ea;
                            res.page_crossed = crossed;
                        end
                        MODE_IND: begin
                            n_phase      = PH_PTRLO;
                            n_work       = base;
                            res.done_res = 1'b0;
                            res.address  = base;
                        end
                        default: begin
                            n_phase     = PH_IDLE;
                            res.address = base;
                        end
                    endcase
                end
                PH_PTRLO: begin
                    n_low        = d;
                    n_phase      = PH_PTRHI;
                    res.done_res = 1'b0;
                    if (r_mode == MODE_IND) begin
                        n_work      = r_work + 16'd1;
                        res.address = r_work + 16'd1;
                    end else begin
                        // zero-page pointer wraps in page zero
                        n_work      = {8'h00, r_work[7:0] + 8'd1};
                        res.address = {8'h00, r_work[7:0] + 8'd1};
                    end
                end
                PH_PTRHI: begin
                    n_phase = PH_IDLE;
                    if (r_mode == MODE_INDY) begin
                        res.address      = ea;
                        res.page_crossed = crossed;
                    end else begin
                        res.address = base;
                    end
                end
                default: begin
                    // data with nothing pending: no state change
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_mode  <= 4'h0;
            r_x     <= 8'h00;
            r_y     <= 8'h00;
            r_value <= 1'b0;
            r_low   <= 8'h00;
            r_work  <= 16'h0000;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_mode  <= n_mode;
            r_x     <= n_x;
            r_y     <= n_y;
            r_value <= n_value;
            r_low   <= n_low;
            r_work  <= n_work;
        end
    end

    assign o_res = res;

endmodule

// File: rtl/core/eau_out_stage.sv
// ---------------------------------------------------------------------------
// eau_out_stage - result register
// Holds one result until the downstream side takes it.
// ---------------------------------------------------------------------------
module eau_out_stage
    import eau_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_ready,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    assign o_free  = ~r_valid | i_ready;
    assign n_valid = i_load | (r_valid & ~i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// File: rtl/core/cpu6502_effective_address_unit.sv
// ---------------------------------------------------------------------------
// cpu6502_effective_address_unit - 6502 addressing mode resolution
// Runs the operand and pointer fetches of a 6502 addressing mode as an
// exchange of items with memory and returns the effective address.
// ---------------------------------------------------------------------------
//  channel  | dir | tdata (lsb up)                              | tuser
//  ---------+-----+---------------------------------------------+-----------
//  s_axis   | in  | mode, operand_address, index_x, index_y,    | func
//           |     | need_value, read_data (45 bits, pad to 48)  |
//  m_axis   | out | address, page_crossed (17 bits, pad to 24)  | done_res
//
//  One item per cycle sustained while m_axis is not stalled; an accepted item
//  is loaded into the input register and its result then into the result
//  register, which raises m_axis tvalid. The step logic between them is
//  16-bit and 8-bit adds and a mode/phase mux.
//  Synchronous active-low reset clears the phase, latches and both valids.
//  A stall on m_axis holds the result; the input register still takes one
//  more item before s_axis tready drops.
// ---------------------------------------------------------------------------
module cpu6502_effective_address_unit
    import eau_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    // mode[3:0], operand_address[19:4], index_x[27:20], index_y[35:28],
    // need_value[36], read_data[44:37], zero pad[47:45]
    input  logic [SDATA_W-1:0] i_s_axis_tdata,
    // func
    input  logic               i_s_axis_tuser,
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    // address[15:0], page_crossed[16], zero pad[23:17]
    output logic [MDATA_W-1:0] o_m_axis_tdata,
    // done_res
    output logic               o_m_axis_tuser
);

    t_in_item   s_item;
    t_in_item   q_item;
    t_result    c_res;
    t_result    q_res;
    t_stage_ctl ctl;
    logic       fire;
    logic       out_free;

    // unpack the slave beat
    assign s_item.func            = i_s_axis_tuser;
    assign s_item.mode            = i_s_axis_tdata[3:0];
    assign s_item.operand_address = i_s_axis_tdata[19:4];
    assign s_item.index_x         = i_s_axis_tdata[27:20];
    assign s_item.index_y         = i_s_axis_tdata[35:28];
    assign s_item.need_value      = i_s_axis_tdata[36];
    assign s_item.read_data       = i_s_axis_tdata[44:37];

    eau_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_item  (s_item),
        .i_take  (out_free),
        .o_fire  (fire),
        .o_ctl   (ctl),
        .o_item  (q_item)
    );

    // state advances only when the result can be stored
    eau_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (q_item),
        .o_res   (c_res)
    );

    eau_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire),
        .i_res   (c_res),
        .i_ready (i_m_axis_tready),
        .o_free  (out_free),
        .o_valid (o_m_axis_tvalid),
        .o_res   (q_res)
    );

    assign o_m_axis_tdata = {7'b0000000, q_res.page_crossed, q_res.address};
    assign o_m_axis_tuser = q_res.done_res;

    // ---- assertions ----

    // a read request never carries a page-cross flag
    a_req_no_cross: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> !o_m_axis_tdata[16])
        else $error("page_crossed set on a read request");

    // every stepped item lands in the result register
    a_fire_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_m_axis_tvalid)
        else $error("stepped item produced no result");

    // full input register behind a stalled result blocks the slave side
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.full && o_m_axis_tvalid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("item accepted with both stages blocked");

    // no step unless the result side has room
    a_step_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |-> ctl.take)
        else $error("step without room for the result");

endmodule
